[design/hsc_pkg.sv]
`timescale 1ns / 1ps

package hsc_pkg;

  // Stream payload widths, padded to whole bytes.
  localparam int InTdataW  = 88;
  localparam int OutTdataW = 48;

  // Configuration port.
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgAddrW-1:0] RegTargetX  = 3'd0;
  localparam logic [CfgAddrW-1:0] RegTargetY  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegKpGain   = 3'd2;
  localparam logic [CfgAddrW-1:0] RegKdGain   = 3'd3;
  localparam logic [CfgAddrW-1:0] RegMaxSteer = 3'd4;

  // Datapath widths.
  localparam int DiffW = 33;  // target minus pose, Q17.16
  localparam int CordW = 56;  // CORDIC x/y, difference scaled by 2^20 plus gain growth
  localparam int AngW  = 33;  // angle in units of 2^-30 rad
  localparam int ErrW  = 35;  // heading error before rounding

  localparam logic signed [AngW-1:0] HalfPiQ30 = 33'sd1686629713;
  localparam logic signed [ErrW-1:0] PiQ30     = 35'sd3373259426;
  localparam logic signed [ErrW-1:0] TwoPiQ30  = 35'sd6746518852;
  localparam logic signed [23:0]     RadToDeg  = 24'sd3754936;   // 180/pi in Q16

  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [AngW-1:0]  ang_t;

  // Arctangent of 2^-k in units of 2^-30 rad, rounded to nearest.
  function automatic logic [29:0] atan_q30(input logic [4:0] k);
    logic [29:0] v;
    unique case (k)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      5'd31: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[design/hsc_cordic.sv]
`timescale 1ns / 1ps

module hsc_cordic #(
  parameter int CORDIC_STEPS = 18
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  hsc_pkg::diff_t x_i,
  input  hsc_pkg::diff_t y_i,
  output logic          done_o,
  output hsc_pkg::ang_t  z_o
);
  import hsc_pkg::*;

  localparam int CntW = $clog2(CORDIC_STEPS);
  localparam logic [CntW-1:0] LastCnt = CntW'(CORDIC_STEPS - 1);

  logic                    busy_q;
  logic                    done_q;
  logic [CntW-1:0]         cnt_q;
  logic                    zero_q;
  logic signed [CordW-1:0] x_q, y_q;
  ang_t                    z_q;

  logic signed [CordW-1:0] xs_in, ys_in, x_sh, y_sh;
  ang_t                    z_step;

  always_comb begin
    xs_in  = CordW'(x_i) <<< 20;
    ys_in  = CordW'(y_i) <<< 20;
    x_sh   = x_q >>> cnt_q;
    y_sh   = y_q >>> cnt_q;
    z_step = signed'({3'b000, atan_q30(5'(cnt_q))});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Vector mode: the left half plane is first rotated by a quarter turn,
  // then each step drives y toward zero and accumulates the angle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_q <= ys_in;
          y_q <= -xs_in;
          z_q <= HalfPiQ30;
        end else begin
          x_q <= -ys_in;
          y_q <= xs_in;
          z_q <= -HalfPiQ30;
        end
      end else begin
        x_q <= xs_in;
        y_q <= ys_in;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + z_step;
      end else begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - z_step;
      end
    end
  end

  assign done_o = done_q;
  assign z_o    = zero_q ? '0 : z_q;

endmodule

[design/heading_steering_controller.sv]
`timescale 1ns / 1ps

// Heading steering controller.
// A pose beat on the slave stream (x, y, heading) is turned into one steering
// beat on the master stream. The block forms the vector from the pose to the
// programmed target, finds its bearing with an iterative CORDIC, wraps the
// heading error into plus or minus pi and applies a PD-style law on the error
// and on the previous steer, scaled to degrees and clamped to max_steer.
// The CORDIC unit does one rotation per cycle, and a single shared 25x24
// multiplier then forms the two gain products and the two halves of the
// degree scaling in turn. One pose is processed at a time; s_axis_tready
// is high only while the sequencer is idle, so a new pose is taken only
// once the previous result has been handed to the output register.
// When the receiver stalls, the finished result waits in the output register
// and the sequencer holds before overwriting it; a new pose can still be
// accepted while an earlier result waits. Configuration writes are applied
// at once and must only be issued while the block is idle.
// Reset clears the target and both gains, sets max_steer to 20 degrees and
// clears the remembered steer.
module heading_steering_controller #(
  parameter int CORDIC_STEPS = 18
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Fields from bit 0: pos_x[31:0], pos_y[63:32], heading[82:64], zero pad.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [hsc_pkg::InTdataW-1:0]   s_axis_tdata,
  // Fields from bit 0: steer_deg[21:0], heading_error[40:22], zero pad.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [hsc_pkg::OutTdataW-1:0]  m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [hsc_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [hsc_pkg::CfgDataW-1:0]   cfg_data_i
);
  import hsc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_CGO   = 4'd2;
  localparam logic [3:0] S_CWAIT = 4'd3;
  localparam logic [3:0] S_ERR   = 4'd4;
  localparam logic [3:0] S_WRAP  = 4'd5;
  localparam logic [3:0] S_SAT   = 4'd6;
  localparam logic [3:0] S_M1    = 4'd7;
  localparam logic [3:0] S_M2    = 4'd8;
  localparam logic [3:0] S_M3    = 4'd9;
  localparam logic [3:0] S_M4    = 4'd10;
  localparam logic [3:0] S_M5    = 4'd11;
  localparam logic [3:0] S_M6    = 4'd12;
  localparam logic [3:0] S_RND   = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  logic [3:0] state_q, state_d;

  // Configuration registers.
  logic signed [31:0] tx_q, ty_q;
  logic signed [23:0] kp_q, kd_q;
  logic [20:0]        max_q;

  // Datapath registers.
  logic signed [31:0] px_q, py_q;
  logic signed [18:0] hd_q;
  diff_t              dx_q, dy_q;
  logic signed [ErrW-1:0] err_q;
  logic signed [18:0] e16_q;
  logic signed [48:0] prod_q;
  logic signed [46:0] acc_q;
  logic signed [61:0] sum_q;
  logic signed [37:0] rnd_q;
  logic signed [21:0] last_q;
  logic               m_valid_q;
  logic signed [21:0] out_steer_q;
  logic signed [18:0] out_err_q;

  logic               in_fire;
  logic               out_free;
  logic               cord_start;
  logic               cord_done;
  ang_t               cord_z;

  logic signed [24:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [48:0] mul_p;
  logic signed [ErrW-1:0] err_rnd;
  logic signed [37:0] max_ext;
  logic signed [21:0] steer_clamped;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign cord_start    = (state_q == S_CGO);

  hsc_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .x_i     (dx_q),
    .y_i     (dy_q),
    .done_o  (cord_done),
    .z_o     (cord_z)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_DIFF;
      S_DIFF:  state_d = S_CGO;
      S_CGO:   state_d = S_CWAIT;
      S_CWAIT: if (cord_done) state_d = S_ERR;
      S_ERR:   state_d = S_WRAP;
      S_WRAP:  state_d = S_SAT;
      S_SAT:   state_d = S_M1;
      S_M1:    state_d = S_M2;
      S_M2:    state_d = S_M3;
      S_M3:    state_d = S_M4;
      S_M4:    state_d = S_M5;
      S_M5:    state_d = S_M6;
      S_M6:    state_d = S_RND;
      S_RND:   state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Shared multiplier. The degree scaling splits the shifted PD sum into an
  // unsigned low part of 20 bits and a signed high part.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_M1: begin
        mul_a = 25'(e16_q);
        mul_b = kp_q;
      end
      S_M2: begin
        mul_a = 25'(last_q);
        mul_b = kd_q;
      end
      S_M4: begin
        mul_a = signed'({5'b00000, acc_q[27:8]});
        mul_b = RadToDeg;
      end
      S_M5: begin
        mul_a = 25'(signed'(acc_q[46:28]));
        mul_b = RadToDeg;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Rounding of the error to Q3.16 and the symmetric clamp of the steer.
  always_comb begin
    err_rnd = (err_q + 35'sd8192) >>> 14;
    max_ext = signed'({17'd0, max_q});
    if (rnd_q > max_ext) begin
      steer_clamped = 22'(max_ext);
    end else if (rnd_q < -max_ext) begin
      steer_clamped = 22'(-max_ext);
    end else begin
      steer_clamped = 22'(rnd_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      last_q    <= '0;
      tx_q      <= '0;
      ty_q      <= '0;
      kp_q      <= '0;
      kd_q      <= '0;
      max_q     <= 21'd1310720;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        m_valid_q <= 1'b1;
        last_q    <= steer_clamped;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          RegTargetX:  tx_q  <= signed'(cfg_data_i);
          RegTargetY:  ty_q  <= signed'(cfg_data_i);
          RegKpGain:   kp_q  <= signed'(cfg_data_i[23:0]);
          RegKdGain:   kd_q  <= signed'(cfg_data_i[23:0]);
          RegMaxSteer: max_q <= cfg_data_i[20:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px_q <= signed'(s_axis_tdata[31:0]);
      py_q <= signed'(s_axis_tdata[63:32]);
      hd_q <= signed'(s_axis_tdata[82:64]);
    end
    unique case (state_q)
      S_DIFF: begin
        dx_q <= DiffW'(tx_q) - DiffW'(px_q);
        dy_q <= DiffW'(ty_q) - DiffW'(py_q);
      end
      S_ERR:  err_q <= ErrW'(cord_z) - (ErrW'(hd_q) <<< 14);
      S_WRAP: begin
        // A single full-turn correction brings the error back toward +-pi.
        if (err_q > PiQ30 || err_q < -PiQ30) begin
          if (err_q < 0) begin
            err_q <= err_q + TwoPiQ30;
          end else begin
            err_q <= err_q - TwoPiQ30;
          end
        end
      end
      S_SAT: begin
        if (err_rnd > 35'sd262143) begin
          e16_q <= 19'sd262143;
        end else if (err_rnd < -35'sd262144) begin
          e16_q <= -19'sd262144;
        end else begin
          e16_q <= 19'(err_rnd);
        end
      end
      S_M1: prod_q <= mul_p;
      S_M2: begin
        acc_q  <= 47'(prod_q);
        prod_q <= mul_p;
      end
      S_M3: acc_q <= acc_q - 47'(prod_q);
      S_M4: prod_q <= mul_p;
      S_M5: begin
        sum_q  <= 62'(prod_q);
        prod_q <= mul_p;
      end
      S_M6:  sum_q <= sum_q + (62'(prod_q) <<< 20);
      S_RND: rnd_q <= 38'((sum_q + 62'sd8388608) >>> 24);
      S_OUT: begin
        if (out_free) begin
          out_steer_q <= steer_clamped;
          out_err_q   <= e16_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, out_err_q, out_steer_q};

endmodule

[dv/steer_checker.sv]
`timescale 1ns / 1ps

// Watches the pose and steering streams and the register port. It predicts
// one steering beat per accepted pose and compares the beats in order.
module steer_checker #(
  parameter int CORDIC_STEPS = 18
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pose_valid_i,
  input  logic                           pose_ready_i,
  // Fields from bit 0: pos_x[31:0], pos_y[63:32], heading[82:64], zero pad.
  input  logic [hsc_pkg::InTdataW-1:0]   pose_data_i,
  input  logic                           steer_valid_i,
  input  logic                           steer_ready_i,
  // Fields from bit 0: steer_deg[21:0], heading_error[40:22], zero pad.
  input  logic [hsc_pkg::OutTdataW-1:0]  steer_data_i,
  input  logic                           cfg_we_i,
  input  logic [hsc_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [hsc_pkg::CfgDataW-1:0]   cfg_data_i,
  output int                             mismatch_cnt_o,
  output int                             steer_due_cnt_o
);

  typedef struct packed {
    logic signed [18:0] heading_error;
    logic signed [21:0] steer_deg;
  } steer_beat_t;

  localparam longint HalfPiQ30   = 64'sd1686629713;
  localparam longint PiQ30       = 64'sd3373259426;
  localparam longint TwoPiQ30    = 64'sd6746518852;
  localparam longint RadToDegQ16 = 64'sd3754936;
  localparam longint ErrHigh     = 64'sd262143;
  localparam longint ErrLow      = -64'sd262144;

  logic signed [31:0] tgt_x = '0;
  logic signed [31:0] tgt_y = '0;
  logic signed [23:0] kp = '0;
  logic signed [23:0] kd = '0;
  logic        [20:0] steer_lim = 21'd1310720;
  logic signed [21:0] prev_steer = '0;

  longint      atan_q30_tab [32];
  steer_beat_t steer_due_q [$];
  int          mismatches = 0;

  // Arctangent of 2^-k in units of 2^-30 rad. From k = 10 to 30 it is 2^(30-k), and 0 at k = 31.
  initial begin
    atan_q30_tab[0] = 843314857;
    atan_q30_tab[1] = 497837829;
    atan_q30_tab[2] = 263043837;
    atan_q30_tab[3] = 133525159;
    atan_q30_tab[4] = 67021687;
    atan_q30_tab[5] = 33543516;
    atan_q30_tab[6] = 16775851;
    atan_q30_tab[7] = 8388437;
    atan_q30_tab[8] = 4194283;
    atan_q30_tab[9] = 2097149;
    for (int k = 10; k < 31; k++) atan_q30_tab[k] = 64'sd1 <<< (30 - k);
    atan_q30_tab[31] = 0;
  end

  function automatic longint bearing_q30(input longint dy, input longint dx);
    longint xv, yv, zv, xs, ys, t;
    int     k;
    if (dx == 0 && dy == 0) return 0;
    xv = dx * 1048576;
    yv = dy * 1048576;
    zv = 0;
    // Left half plane: pre-rotate by a quarter turn so the iterations converge.
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv;
        yv = -t;
        zv = HalfPiQ30;
      end else begin
        xv = -yv;
        yv = t;
        zv = -HalfPiQ30;
      end
    end
    for (k = 0; k < CORDIC_STEPS; k++) begin
      xs = xv >>> (k % 32);
      ys = yv >>> (k % 32);
      if (yv > 0) begin
        xv += ys;
        yv -= xs;
        zv += atan_q30_tab[k % 32];
      end else begin
        xv -= ys;
        yv += xs;
        zv -= atan_q30_tab[k % 32];
      end
    end
    return zv;
  endfunction

  function automatic steer_beat_t predict_steer(input logic signed [31:0] px,
                                                input logic signed [31:0] py,
                                                input logic signed [18:0] hd);
    longint      err, e16, raw, deg, lim;
    steer_beat_t beat;
    err = bearing_q30(longint'(tgt_y) - longint'(py), longint'(tgt_x) - longint'(px))
          - longint'(hd) * 16384;
    if (err > PiQ30 || err < -PiQ30) err = (err < 0) ? err + TwoPiQ30 : err - TwoPiQ30;
    e16 = (err + 8192) >>> 14;
    if (e16 > ErrHigh) e16 = ErrHigh;
    if (e16 < ErrLow) e16 = ErrLow;
    raw = longint'(kp) * e16 - longint'(kd) * longint'(prev_steer);
    deg = ((raw >>> 8) * RadToDegQ16 + (64'sd1 <<< 23)) >>> 24;
    lim = longint'(steer_lim);
    if (deg > lim) deg = lim;
    if (deg < -lim) deg = -lim;
    beat.steer_deg     = deg[21:0];
    beat.heading_error = e16[18:0];
    return beat;
  endfunction

  task automatic flag_mismatch(input string field, input longint want, input longint got);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    steer_beat_t want, got;
    if (!rst_ni) begin
      tgt_x      = '0;
      tgt_y      = '0;
      kp         = '0;
      kd         = '0;
      steer_lim  = 21'd1310720;
      prev_steer = '0;
      steer_due_q.delete();
      mismatches = 0;
      mismatch_cnt_o  <= 0;
      steer_due_cnt_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          hsc_pkg::RegTargetX:  tgt_x = cfg_data_i;
          hsc_pkg::RegTargetY:  tgt_y = cfg_data_i;
          hsc_pkg::RegKpGain:   kp = cfg_data_i[23:0];
          hsc_pkg::RegKdGain:   kd = cfg_data_i[23:0];
          hsc_pkg::RegMaxSteer: steer_lim = cfg_data_i[20:0];
          default: ;
        endcase
      end
      if (pose_valid_i && pose_ready_i) begin
        want = predict_steer(pose_data_i[31:0], pose_data_i[63:32], pose_data_i[82:64]);
        prev_steer = want.steer_deg;
        steer_due_q.push_back(want);
      end
      if (steer_valid_i && steer_ready_i) begin
        got = steer_data_i[40:0];
        if (steer_due_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: steering beat with none expected, got %h", $time, steer_data_i);
        end else begin
          want = steer_due_q.pop_front();
          if (got.steer_deg !== want.steer_deg)
            flag_mismatch("steer_deg", want.steer_deg, got.steer_deg);
          if (got.heading_error !== want.heading_error)
            flag_mismatch("heading_error", want.heading_error, got.heading_error);
        end
      end
      mismatch_cnt_o  <= mismatches;
      steer_due_cnt_o <= steer_due_q.size();
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

// Top of the testbench. It drives poses and register writes into the
// steering controller, stalls the result stream at random, and leaves all
// prediction and comparison to the checker that sits beside the block.
module tb;

  localparam int CordicSteps  = 18;
  localparam int CycleLimit   = 2000000;
  localparam int RandomPhases = 10;
  localparam int PhaseBeats   = 175;
  // Wait after the final drain, scaled with the CORDIC step count.
  localparam int DrainCycles  = CordicSteps + 30;

  localparam logic signed [31:0] PosMax          = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PosMin          = 32'sh8000_0000;
  localparam logic signed [31:0] Metre           = 32'sd65536;
  localparam logic signed [18:0] HdgMax          = 19'sh3FFFF;
  localparam logic signed [18:0] HdgMin          = 19'sh40000;
  localparam logic signed [18:0] PiQ16           = 19'sd205887;
  localparam logic signed [23:0] GainMax         = 24'sh7FFFFF;
  localparam logic signed [23:0] GainMin         = 24'sh800000;
  localparam logic signed [23:0] GainOne         = 24'sd65536;
  localparam logic        [20:0] SteerLimDefault = 21'd1310720;
  localparam logic        [20:0] SteerLimMax     = 21'h1FFFFF;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  // Fields from bit 0: pos_x[31:0], pos_y[63:32], heading[82:64], zero pad.
  logic [hsc_pkg::InTdataW-1:0]  s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // Fields from bit 0: steer_deg[21:0], heading_error[40:22], zero pad.
  logic [hsc_pkg::OutTdataW-1:0] m_axis_tdata;
  logic                          cfg_we_i = 1'b0;
  logic [hsc_pkg::CfgAddrW-1:0]  cfg_addr_i = '0;
  logic [hsc_pkg::CfgDataW-1:0]  cfg_data_i = '0;

  int mismatch_cnt;
  int steer_due_cnt;
  int cycle_cnt;

  // Idling controls, changed from phase to phase so that some stretches run
  // back to back on both sides.
  bit tx_gaps   = 1'b0;
  bit rx_stalls = 1'b0;
  int rx_hold   = 0;

  // The current target, so that random poses can be placed around it.
  logic signed [31:0] cur_tx = '0;
  logic signed [31:0] cur_ty = '0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  heading_steering_controller #(
    .CORDIC_STEPS(CordicSteps)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  steer_checker #(
    .CORDIC_STEPS(CordicSteps)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pose_valid_i    (s_axis_tvalid),
    .pose_ready_i    (s_axis_tready),
    .pose_data_i     (s_axis_tdata),
    .steer_valid_i   (m_axis_tvalid),
    .steer_ready_i   (m_axis_tready),
    .steer_data_i    (m_axis_tdata),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_cnt_o  (mismatch_cnt),
    .steer_due_cnt_o (steer_due_cnt)
  );

  // Idle lengths: mostly short, now and then long enough to cover the
  // whole CORDIC run and the multiplier passes behind it.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // Receiver side. While stalls are enabled, a stall of random length starts
  // on about a quarter of the cycles; otherwise tready stays high.
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_stalls && $urandom_range(0, 99) < 25) begin
      rx_hold <= pick_gap() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Offers one pose beat and returns at the edge where it is taken. tvalid is
  // left high, so the next beat may follow with no gap; it is lowered only
  // when a gap or a drain comes next.
  task automatic send_pose(input logic signed [31:0] x, input logic signed [31:0] y,
                           input logic signed [18:0] hd);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {5'd0, hd, y, x};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Holds the sender back until every predicted steering beat has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (steer_due_cnt != 0);
  endtask

  // Writes all registers, plus the unused indexes above them, on an idle
  // block. Bits above a register's width carry random junk, which the block
  // must ignore, and so must the writes to the unused indexes.
  task automatic apply_settings(input logic signed [31:0] tx, input logic signed [31:0] ty,
                                input logic signed [23:0] kp, input logic signed [23:0] kd,
                                input logic [20:0] lim);
    logic [hsc_pkg::CfgDataW-1:0] word [1 << hsc_pkg::CfgAddrW];
    for (int a = 0; a < (1 << hsc_pkg::CfgAddrW); a++) word[a] = $urandom();
    word[hsc_pkg::RegTargetX]        = tx;
    word[hsc_pkg::RegTargetY]        = ty;
    word[hsc_pkg::RegKpGain][23:0]   = kp;
    word[hsc_pkg::RegKdGain][23:0]   = kd;
    word[hsc_pkg::RegMaxSteer][20:0] = lim;
    drain();
    cur_tx = tx;
    cur_ty = ty;
    for (int a = 0; a < (1 << hsc_pkg::CfgAddrW); a++) begin
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= a[hsc_pkg::CfgAddrW-1:0];
      cfg_data_i <= word[a];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Random settings: targets mostly within a kilometre, gains mostly small
  // enough that the clamp does not hide the arithmetic, with full-range
  // values mixed in.
  task automatic random_settings();
    logic signed [31:0] tx, ty;
    logic signed [23:0] kp, kd;
    logic        [20:0] lim;
    int                 pick;
    if ($urandom_range(0, 9) < 7) begin
      tx = $urandom_range(0, 131072000) - 65536000;
      ty = $urandom_range(0, 131072000) - 65536000;
    end else begin
      tx = $urandom();
      ty = $urandom();
    end
    pick = $urandom_range(0, 9);
    if (pick < 6)      kp = 24'($urandom_range(0, 524288) - 262144);
    else if (pick < 8) kp = 24'($urandom_range(0, 32768) - 16384);
    else               kp = 24'($urandom());
    pick = $urandom_range(0, 9);
    if (pick < 5)      kd = 24'($urandom_range(0, 131072) - 65536);
    else if (pick < 7) kd = '0;
    else               kd = 24'($urandom());
    pick = $urandom_range(0, 9);
    if (pick < 4)      lim = SteerLimDefault;
    else if (pick < 8) lim = 21'($urandom());
    else if (pick < 9) lim = '0;
    else               lim = SteerLimMax;
    apply_settings(tx, ty, kp, kd, lim);
  endtask

  // Random pose: near the target, on it, on an axis through it, or anywhere.
  // Headings are mostly inside plus or minus pi, the rest span all 19 bits.
  task automatic random_pose();
    logic signed [31:0] x, y;
    logic signed [18:0] hd;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        x = cur_tx + ($urandom_range(0, 2097152) - 1048576);
        y = cur_ty + ($urandom_range(0, 2097152) - 1048576);
      end
      4: begin
        x = cur_tx;
        y = cur_ty;
      end
      5: begin
        x = cur_tx;
        y = ($urandom_range(0, 1) == 1) ? $urandom() : cur_ty + $urandom_range(0, 65536) - 32768;
      end
      6: begin
        x = ($urandom_range(0, 1) == 1) ? $urandom() : cur_tx + $urandom_range(0, 65536) - 32768;
        y = cur_ty;
      end
      default: begin
        x = $urandom();
        y = $urandom();
      end
    endcase
    if ($urandom_range(0, 9) < 7) hd = 19'($urandom_range(0, 2 * 205887) - 205887);
    else                          hd = 19'($urandom());
    send_pose(x, y, hd);
  endtask

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("heading_steering_controller verification failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;

    // Reset values: zero gains give zero steer. The target sits on the
    // pose first, then the vector points along the negative x axis.
    send_pose(0, 0, 0);
    send_pose(Metre, 0, 0);

    // Unit gain with a quarter of the old steer fed back.
    apply_settings(0, 0, GainOne, GainOne >>> 2, SteerLimDefault);
    send_pose(0, 0, 0);
    send_pose(5 * Metre, 0, 0);
    send_pose(-3 * Metre, 0, HdgMax);
    send_pose(-3 * Metre, 0, HdgMin);
    send_pose(0, -2 * Metre, 0);
    send_pose(0, 2 * Metre, 0);
    send_pose(Metre, Metre, 0);
    send_pose(-Metre, Metre, 0);
    send_pose(Metre, -Metre, PiQ16);

    // Extreme corners: largest vectors, largest gains, widest clamp.
    apply_settings(PosMin, PosMax, GainMax, GainMin, SteerLimMax);
    send_pose(PosMax, PosMin, HdgMax);
    send_pose(PosMax, PosMax, HdgMin);
    send_pose(PosMin, PosMin, 0);
    send_pose(0, 0, HdgMin);
    send_pose(32'sh5555_5555, 32'shAAAA_AAAA, 19'sh2AAAA);
    send_pose(32'shAAAA_AAAA, 32'sh5555_5555, 19'sh15555);

    // Opposite corners with a zero clamp: every steer must come out as zero.
    apply_settings(PosMax, PosMin, GainMin, GainMax, '0);
    send_pose(PosMin, PosMax, HdgMax);
    send_pose(PosMax, PosMin, 0);
    send_pose(0, 0, -PiQ16);

    // Negative gains: the steer follows the error with the opposite sign.
    apply_settings(0, 0, -GainOne, -GainOne, SteerLimMax);
    send_pose(Metre, 0, PiQ16);
    send_pose(0, Metre, -PiQ16);
    send_pose(-Metre, -Metre, 0);

    for (int phase = 0; phase < RandomPhases; phase++) begin
      tx_gaps   = (phase % 3) != 0;
      rx_stalls = (phase % 4) != 1;
      random_settings();
      for (int n = 0; n < PhaseBeats; n++) begin
        // Now and then the sender waits for every result before going on.
        if ($urandom_range(0, 99) < 2) drain();
        random_pose();
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && steer_due_cnt == 0) begin
      $display("heading_steering_controller verification clean");
    end else begin
      $display("heading_steering_controller verification failed");
    end
    $finish;
  end

endmodule
